### hw/rtl/bitmap_block_allocator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap block allocator
// Wrap concurrent checks so that synthesis sees nothing.
// ---------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge outside of reset.
`define BBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition implies another in the next cycle.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT(label, prop, msg)
`define BBA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hw/rtl/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

  localparam int ID_W       = 15;
  localparam int STATUS_W   = 2;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [ID_W-1:0] FDB_RESET = 15'd1036;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } bba_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_write;
    logic load;
    logic rd;
    logic commit;
    logic finish;
    logic advance;
    logic out_load;
  } bba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic act_free;
    logic reject;
    logic found;
    logic last_word;
    logic out_room;
  } bba_sts_t;

endpackage

### hw/rtl/bitmap_block_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over a one-bit-per-block free map held in RAM.
// ---------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tuser: action; tdata: free_id
//  m_axis    out        tdata: granted_block; tuser: status
//  cfg       in         first_data_block, written on cfg_we
//
//  After reset the map is swept clear, one 32-bit word a cycle, over all
//  ceil(BLOCK_COUNT/32) words (1024 at the default) with s_axis_tready low.
//  A rejected request goes from its read straight to done, a free reads and
//  checks its one word, an allocate does one RAM read and one check per word.
//  A new request is taken only after the last result is loaded out.
//  A held result lets one more request in, which then waits for room.
// ---------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int BLOCK_COUNT = 32768
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [bba_pkg::ID_W-1:0]            cfg_wdata,  // first_data_block
  // requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [14:0] free_id
  input  logic                                s_axis_tuser,  // [0] action
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [14:0] granted_block
  output logic [bba_pkg::STATUS_W-1:0]        m_axis_tuser   // [1:0] status
);

  import bba_pkg::*;

  bba_cmd_t        cmd;
  bba_sts_t        sts;
  logic [ID_W-1:0] out_block;

  // Sequence the sweep, the scan and the hand-off of each word.
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the map, the request and the output word.
  bba_dp #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_action   (s_axis_tuser),
    .in_free_id  (s_axis_tdata[ID_W-1:0]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_block   (out_block),
    .out_status  (m_axis_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Pad the granted block to whole bytes.
  assign m_axis_tdata = OUT_DATA_W'(out_block);

endmodule

### hw/rtl/bba_ram.sv
// ---------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM with registered read.
// ---------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// Controller: clearing pass, request sequencing and result hand-off.
// ---------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_cmd_t cmd
);

  import bba_pkg::*;

  bba_state_t state;
  bba_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = sts.reject ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.act_free || sts.found || sts.last_word) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (sts.out_room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: begin
        cmd.finish = sts.reject;
        cmd.rd     = !sts.reject;
      end
      ST_CHECK: begin
        cmd.commit  = sts.act_free || sts.found;
        cmd.finish  = sts.act_free || sts.found || sts.last_word;
        cmd.advance = !(sts.act_free || sts.found || sts.last_word);
      end
      ST_DONE: begin
        cmd.out_load = sts.out_room;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `BBA_ASSERT(a_commit_in_check, cmd.commit |-> state == ST_CHECK, "map write outside check")
  `BBA_ASSERT(a_out_load_room, cmd.out_load |-> sts.out_room, "result overwrites pending word")
  `BBA_ASSERT_NEXT(a_advance_reads, cmd.advance, state == ST_READ, "scan advance lost")

endmodule

### hw/rtl/bba_dp.sv
// ---------------------------------------------------------------------------
// bba_dp
// Datapath: free map RAM, word scan, request registers and output register.
// ---------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bba_dp #(
  parameter int BLOCK_COUNT = 32768
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bba_pkg::ID_W-1:0]       cfg_wdata,
  input  logic                           in_action,
  input  logic [bba_pkg::ID_W-1:0]       in_free_id,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [bba_pkg::ID_W-1:0]       out_block,
  output logic [bba_pkg::STATUS_W-1:0]   out_status,
  input  bba_pkg::bba_cmd_t              cmd,
  output bba_pkg::bba_sts_t              sts
);

  import bba_pkg::*;

  localparam int WORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W = AW + BIT_W;
  localparam int TAIL  = BLOCK_COUNT % WORD_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (TAIL == 0) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));

  logic [ID_W-1:0]     fdb;
  logic                act;
  logic [ID_W-1:0]     bid;
  logic [AW-1:0]       widx;
  logic                first;
  logic [AW-1:0]       clr_addr;
  logic [ID_W-1:0]     res_block;
  logic [STATUS_W-1:0] res_status;

  logic [WORD_W-1:0]   rd_data;
  logic [WORD_W-1:0]   scan_word;
  logic [WORD_W-1:0]   low_mask;
  logic                found;
  logic [BIT_W-1:0]    fbit;
  logic [IDX_W-1:0]    blk;
  logic                illegal;
  logic                start_full;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fdb <= FDB_RESET;
    end else if (cfg_we) begin
      fdb <= cfg_wdata;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Request registers and scan pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= in_action;
      bid   <= in_free_id;
      first <= 1'b1;
      widx  <= (in_action == ACT_FREE) ? AW'(in_free_id >> BIT_W) : AW'(fdb >> BIT_W);
    end else if (cmd.advance) begin
      first <= 1'b0;
      widx  <= widx + AW'(1);
    end
  end

  assign illegal    = (bid < fdb) || (32'(bid) >= BLOCK_COUNT);
  assign start_full = 32'(fdb) >= BLOCK_COUNT;

  // Treat bits below the data area and past the last block as taken.
  assign low_mask  = first ? ((WORD_W'(1) << fdb[BIT_W-1:0]) - WORD_W'(1)) : '0;
  assign scan_word = rd_data | low_mask | ((widx == LAST_WORD) ? TAIL_MASK : '0);

  always_comb begin
    found = 1'b0;
    fbit  = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!scan_word[i]) begin
        found = 1'b1;
        fbit  = BIT_W'(i);
      end
    end
  end

  assign blk = {widx, fbit};

  assign ram_we    = cmd.clr_write || cmd.commit;
  assign ram_waddr = cmd.clr_write ? clr_addr : widx;

  always_comb begin
    if (cmd.clr_write) begin
      ram_wdata = '0;
    end else if (act == ACT_FREE) begin
      ram_wdata = rd_data & ~(WORD_W'(1) << bid[BIT_W-1:0]);
    end else begin
      ram_wdata = rd_data | (WORD_W'(1) << fbit);
    end
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.rd),
    .rd_addr (widx),
    .rd_data (rd_data)
  );

  // Result of the finished request.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (act == ACT_FREE) begin
        res_block  <= '0;
        res_status <= illegal ? STATUS_ILLEGAL : STATUS_OK;
      end else if (cmd.commit) begin
        res_block  <= ID_W'(blk);
        res_status <= STATUS_OK;
      end else begin
        res_block  <= '0;
        res_status <= STATUS_FULL;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_block  <= res_block;
      out_status <= res_status;
    end
  end

  always_comb begin
    sts           = '0;
    sts.clr_last  = clr_addr == LAST_WORD;
    sts.act_free  = act == ACT_FREE;
    sts.reject    = (act == ACT_FREE) ? illegal : start_full;
    sts.found     = found;
    sts.last_word = widx == LAST_WORD;
    sts.out_room  = !out_valid || out_ready;
  end

  `BBA_ASSERT(a_alloc_bit_clear,
    (cmd.commit && act == ACT_ALLOC) |-> !rd_data[fbit],
    "granted a used block")
  `BBA_ASSERT(a_alloc_in_range,
    (cmd.commit && act == ACT_ALLOC) |-> (32'(blk) >= 32'(fdb) && 32'(blk) < BLOCK_COUNT),
    "granted block out of range")
  `BBA_ASSERT(a_read_in_map, cmd.rd |-> 32'(widx) < WORDS, "map read past last word")

endmodule

### bench/bitmap_block_allocator_tb.sv
// ---------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Drives allocate and free requests into the block allocator and checks
// every result word against a bit-accurate copy of the free map kept here.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int NBLK      = 32768;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_LEN = 48;

  // -------------------------------------------------------------------------
  // Free map mirror: predicts grant and status per request, holds the
  // expected result words in acceptance order.
  // -------------------------------------------------------------------------
  class alloc_scoreboard;
    bit              used_bits [NBLK];
    logic [ID_W-1:0] data_start;
    logic [ID_W-1:0] grant_q [$];
    logic [STATUS_W-1:0] status_q [$];
    int              live_q [$];   // blocks granted so far, candidates to free
    int              errors;

    function new();
      data_start = FDB_RESET;
      errors     = 0;
    endfunction

    function void set_start(logic [ID_W-1:0] v);
      data_start = v;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    // Work out the result of one accepted request word and update the map.
    function void note_request(logic act, logic [ID_W-1:0] id);
      logic [ID_W-1:0]     grant;
      logic [STATUS_W-1:0] st;
      int                  cur;
      grant = '0;
      st    = STATUS_OK;
      if (act == ACT_ALLOC) begin
        st = STATUS_FULL;
        for (cur = int'(data_start); cur < NBLK; cur++) begin
          if (!used_bits[cur]) begin
            used_bits[cur] = 1'b1;
            grant          = cur[ID_W-1:0];
            st             = STATUS_OK;
            live_q         = {live_q, cur};
            break;
          end
        end
      end else begin
        if (id < data_start || int'(id) >= NBLK) st = STATUS_ILLEGAL;
        else used_bits[id] = 1'b0;
      end
      grant_q  = {grant_q, grant};
      status_q = {status_q, st};
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] st);
      logic [OUT_DATA_W-1:0] want_data;
      logic [STATUS_W-1:0]   want_st;
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: data %h status %0d",
                 $time, data, st);
        return;
      end
      want_data           = '0;
      want_data[ID_W-1:0] = grant_q.pop_front();
      want_st             = status_q.pop_front();
      if (data !== want_data) begin
        errors++;
        $display("%0t: granted_block mismatch: expected %h actual %h",
                 $time, want_data, data);
      end
      if (st !== want_st) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want_st, st);
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [ID_W-1:0]       cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [14:0] free_id
  logic                  s_axis_tuser = 1'b0; // [0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [14:0] granted_block
  logic [STATUS_W-1:0]   m_axis_tuser;         // [1:0] status

  always #5 clk = ~clk;

  bitmap_block_allocator #(
    .BLOCK_COUNT(NBLK)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  alloc_scoreboard sb = new();

  // Idle controls: src_idle_on is read only by the stimulus process, so it
  // takes blocking writes; sink_idle_on feeds the receiver.
  logic src_idle_on  = 1'b0;
  logic sink_idle_on = 1'b0;
  int   hold_reqs    = 0;   // bump to ask the receiver for one long hold-off

  // -------------------------------------------------------------------------
  // Receiver: random back-pressure bursts, plus a long hold on request.
  // The long hold is counted here, independent of the sender.
  // -------------------------------------------------------------------------
  int sink_gap  = 0;
  int sink_hold = 0;
  int hold_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap  = 0;
      sink_hold = 0;
    end else if (hold_done != hold_reqs) begin
      // start a long stall so the block fills up and drops s_axis_tready
      hold_done = hold_reqs;
      sink_hold = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor: every accepted result word is checked in order.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // -------------------------------------------------------------------------
  // Sender tasks. tvalid is not lowered after an accept; the next word or
  // an idle burst decides its next value, so it gets one write per step.
  // -------------------------------------------------------------------------
  task automatic idle_src(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(input logic act, input logic [ID_W-1:0] id);
    if (src_idle_on && $urandom_range(0, 3) == 0) idle_src($urandom_range(1, 17));
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(IN_DATA_W-ID_W){1'b0}}, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(act, id);
  endtask

  // Hold the sender until every expected word is back, then let the block
  // settle before anything else touches it.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start(input logic [ID_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_start(v);
    cfg_we <= 1'b0;
  endtask

  // One random request: mostly allocates and frees of granted blocks,
  // the rest noise ids and ids at the edge of the data area.
  task automatic random_request();
    int              r;
    int              idx;
    logic [ID_W-1:0] id;
    r  = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, NBLK - 1));
    if (r < 50) begin
      send_request(ACT_ALLOC, id);
    end else if (r < 80 && sb.live_q.size() > 0) begin
      idx = $urandom_range(0, sb.live_q.size() - 1);
      id  = ID_W'(sb.live_q[idx]);
      sb.live_q.delete(idx);
      send_request(ACT_FREE, id);
    end else if (r < 88) begin
      // straddle the lower bound of the data area
      id = sb.data_start - ID_W'($urandom_range(0, 1));
      send_request(ACT_FREE, id);
    end else begin
      send_request(ACT_FREE, id);
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int              p;
    int              k;
    logic [ID_W-1:0] start_v;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: default data start, first fit, double free, bounds.
    src_idle_on  = 1'b1;
    sink_idle_on <= 1'b1;
    send_request(ACT_ALLOC, '0);                 // lowest data block
    send_request(ACT_ALLOC, '1);                 // id ignored on allocate
    send_request(ACT_FREE, FDB_RESET);
    send_request(ACT_FREE, FDB_RESET);           // already free, still ok
    send_request(ACT_ALLOC, 15'h5555);           // refills the hole
    send_request(ACT_FREE, FDB_RESET - 15'd1);   // just below the data area
    send_request(ACT_FREE, '0);
    send_request(ACT_FREE, '1);                  // top block, legal
    send_request(ACT_FREE, 15'h2AAA);

    // Data area from zero: block 0 is a real grant with ok status.
    write_start('0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, '0);
    send_request(ACT_ALLOC, '0);

    // Data area of one block: grant it, then the map is full.
    write_start('1);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, 15'h7FFE);
    send_request(ACT_FREE, '1);
    send_request(ACT_ALLOC, '1);
    send_request(ACT_FREE, '1);
    send_request(ACT_FREE, '0);

    // Random phases over several data starts; the last one runs without
    // idling on either side.
    for (p = 0; p < 8; p++) begin
      case (p)
        0: start_v = FDB_RESET;
        1: start_v = ID_W'($urandom_range(1, 64));
        2: start_v = ID_W'($urandom_range(NBLK - 32, NBLK - 2));
        3: start_v = '0;
        4: start_v = ID_W'($urandom_range(0, NBLK - 1));
        5: start_v = '1;
        6: start_v = ID_W'($urandom_range(900, 1200));
        default: start_v = FDB_RESET;
      endcase
      write_start(start_v);
      src_idle_on  = (p != 1) && (p != 5) && (p != 7);
      sink_idle_on <= (p != 3) && (p != 7);
      if (p == 1) begin
        // receiver stalls long while words keep coming back to back
        hold_reqs <= hold_reqs + 1;
      end
      for (k = 0; k < PHASE_LEN; k++) random_request();
    end

    // Wrap up: wait for the last words, then catch any stray one.
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dp.sv
hw/rtl/bitmap_block_allocator.sv
bench/bitmap_block_allocator_tb.sv
